/* hdl/sv48_page_table_walk_and_build_defines.svh */
// Shared assertion macros for the page table walker checks.
`ifndef SV48_PAGE_TABLE_WALK_AND_BUILD_DEFINES_SVH
`define SV48_PAGE_TABLE_WALK_AND_BUILD_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define SV48PTW_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sv48ptw check failed");

// Next-cycle implication, disabled in reset
`define SV48PTW_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sv48ptw check failed");

`endif

/* hdl/sv48ptw_pkg.sv */
`timescale 1ns / 1ps
package sv48ptw_pkg;

    localparam int TABLE_PAGES = 8;
    localparam int IDX_W       = 9;
    localparam int PAGE_W      = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
    localparam int ADDR_W      = PAGE_W + IDX_W;
    localparam int NTP_W       = $clog2(TABLE_PAGES + 1);
    localparam int STORE_DEPTH = TABLE_PAGES * (1 << IDX_W);
    localparam int PPN_W       = 44;
    localparam int PTE_W       = 54;
    localparam int VA_W        = 48;
    localparam int PA_W        = 56;
    localparam int LIM_W       = 32;

    // Operation codes
    localparam logic [1:0] OP_TRANSLATE = 2'd0;
    localparam logic [1:0] OP_MAP       = 2'd1;
    localparam logic [1:0] OP_POPULATE  = 2'd2;

    // Status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOTMAPPED = 3'd1;
    localparam logic [2:0] ST_ALREADY   = 3'd2;
    localparam logic [2:0] ST_USER      = 3'd3;
    localparam logic [2:0] ST_NOPAGES   = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] REG_TABLE_BASE = 2'd0;
    localparam logic [1:0] REG_DATA_BASE  = 2'd1;
    localparam logic [1:0] REG_DATA_LIMIT = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic              start;
        logic              clear;
        logic [ADDR_W-1:0] clr_addr;
        logic              rd;
        logic              eval;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic done;
    } sts_t;

endpackage

/* hdl/sv48ptw_dp.sv */
`timescale 1ns / 1ps
module sv48ptw_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  sv48ptw_pkg::cmd_t             cmd,
    output sv48ptw_pkg::sts_t             sts,
    input  logic [1:0]                    s_op,
    input  logic [47:0]                   s_virt_addr,
    input  logic [55:0]                   s_phys_addr,
    input  logic [1:0]                    s_level,
    input  logic                          s_user,
    input  logic                          s_writable,
    input  logic                          s_executable,
    input  logic [43:0]                   table_base_ppn,
    input  logic [43:0]                   data_base_ppn,
    input  logic [31:0]                   data_page_limit,
    output logic [2:0]                    m_status,
    output logic [55:0]                   m_result_addr,
    output logic [4:0]                    m_leaf_flags,
    output logic                          m_flags_changed
);
    import sv48ptw_pkg::*;

    logic [PTE_W-1:0]  store [STORE_DEPTH];
    logic [PTE_W-1:0]  pte_reg;
    logic [1:0]        op_reg;
    logic [VA_W-1:0]   va_reg;
    logic [PPN_W-1:0]  pa_ppn_reg;
    logic [1:0]        tgt_reg;
    logic              u_reg, w_reg, x_reg;
    logic [1:0]        lvl_reg;
    logic [PAGE_W-1:0] page_reg;
    logic [NTP_W-1:0]  ntp_reg;
    logic [LIM_W-1:0]  ndp_reg;
    logic [2:0]        st_reg;
    logic [PA_W-1:0]   addr_reg;
    logic [4:0]        fl_reg;
    logic              ch_reg;

    logic [IDX_W-1:0]  vidx;
    logic [ADDR_W-1:0] slot;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [PTE_W-1:0]  mem_wdata;

    logic              ev_done, ev_we, ev_desc, ev_alloc, ev_dinc, ev_ch;
    logic [2:0]        ev_st;
    logic [PA_W-1:0]   ev_addr;
    logic [4:0]        ev_fl;
    logic [PTE_W-1:0]  ev_wdata;
    logic [PAGE_W-1:0] ev_page;

    // Pick the index bits of the current level
    always_comb begin
        case (lvl_reg)
            2'd3:    vidx = va_reg[47:39];
            2'd2:    vidx = va_reg[38:30];
            2'd1:    vidx = va_reg[29:21];
            default: vidx = va_reg[20:12];
        endcase
    end

    assign slot = {page_reg, vidx};

    // Decide the outcome of one fetched entry
    always_comb begin
        logic             v, leaf, stray, full, is_tr;
        logic [4:0]       fl5, req, newf;
        logic [PPN_W-1:0] ppn, off, new_ppn;
        logic [PA_W-1:0]  pg_addr, sz_mask;
        v       = pte_reg[0];
        leaf    = pte_reg[1] | pte_reg[3];
        fl5     = pte_reg[4:0];
        ppn     = pte_reg[PTE_W-1:10];
        pg_addr = {ppn, 12'b0};
        off     = ppn - table_base_ppn;
        stray   = (off >= PPN_W'(TABLE_PAGES));
        full    = (ntp_reg >= NTP_W'(TABLE_PAGES));
        is_tr   = (op_reg != OP_MAP) && (op_reg != OP_POPULATE);
        req     = {u_reg, x_reg, w_reg, 2'b11};
        newf    = {u_reg, fl5[3] | x_reg, fl5[2] | w_reg, 2'b11};
        new_ppn = '0;
        case (lvl_reg)
            2'd0:    sz_mask = PA_W'(56'hFFF);
            2'd1:    sz_mask = PA_W'(56'h1F_FFFF);
            2'd2:    sz_mask = PA_W'(56'h3FFF_FFFF);
            default: sz_mask = PA_W'(56'h7F_FFFF_FFFF);
        endcase

        ev_done  = 1'b0;
        ev_we    = 1'b0;
        ev_desc  = 1'b0;
        ev_alloc = 1'b0;
        ev_dinc  = 1'b0;
        ev_ch    = 1'b0;
        ev_st    = ST_OK;
        ev_addr  = '0;
        ev_fl    = '0;
        ev_wdata = '0;
        ev_page  = off[PAGE_W-1:0];

        if (is_tr) begin
            // Translate: follow pointers, stop at a leaf
            if (!v) begin
                ev_done = 1'b1;
                ev_st   = ST_NOTMAPPED;
            end else if (leaf) begin
                ev_done = 1'b1;
                ev_addr = (pg_addr & ~sz_mask) | ({8'b0, va_reg} & sz_mask);
                ev_fl   = fl5;
            end else if (lvl_reg == 2'd0 || stray) begin
                ev_done = 1'b1;
                ev_st   = ST_NOTMAPPED;
            end else begin
                ev_desc = 1'b1;
            end
        end else if (lvl_reg != tgt_reg) begin
            // Build walk above the target level
            if (v) begin
                if (leaf) begin
                    ev_done = 1'b1;
                    ev_st   = ST_ALREADY;
                    ev_addr = pg_addr;
                    ev_fl   = fl5;
                end else if (stray) begin
                    ev_done = 1'b1;
                    ev_st   = ST_NOTMAPPED;
                end else begin
                    ev_desc = 1'b1;
                end
            end else if (full) begin
                ev_done = 1'b1;
                ev_st   = ST_NOPAGES;
            end else begin
                new_ppn  = table_base_ppn + PPN_W'(ntp_reg);
                ev_we    = 1'b1;
                ev_wdata = {new_ppn, 10'b1};
                ev_alloc = 1'b1;
                ev_desc  = 1'b1;
                ev_page  = ntp_reg[PAGE_W-1:0];
            end
        end else if (op_reg == OP_MAP) begin
            // Map: write the leaf into an empty slot, or report an occupied slot as already mapped
            if (v) begin
                ev_done = 1'b1;
                ev_st   = ST_ALREADY;
                ev_addr = pg_addr;
                ev_fl   = fl5;
            end else begin
                ev_done  = 1'b1;
                ev_we    = 1'b1;
                ev_wdata = {pa_ppn_reg, 5'b0, 1'b0, x_reg, w_reg, 2'b11};
                ev_addr  = {pa_ppn_reg, 12'b0};
                ev_fl    = {1'b0, x_reg, w_reg, 2'b11};
            end
        end else begin
            // Populate: allocate a data page, merge flags, or report a user-bit mismatch or an exhausted data pool
            ev_done = 1'b1;
            if (!v) begin
                if (ndp_reg >= data_page_limit) begin
                    ev_st = ST_NOPAGES;
                end else begin
                    new_ppn  = data_base_ppn + PPN_W'(ndp_reg);
                    ev_we    = 1'b1;
                    ev_dinc  = 1'b1;
                    ev_wdata = {new_ppn, 5'b0, req};
                    ev_addr  = {new_ppn, 12'b0};
                    ev_fl    = req;
                end
            end else if (fl5[4] != u_reg) begin
                ev_st   = ST_USER;
                ev_addr = pg_addr;
                ev_fl   = fl5;
            end else begin
                ev_ch    = (newf != fl5);
                ev_we    = ev_ch;
                ev_wdata = {pte_reg[PTE_W-1:5], newf};
                ev_addr  = pg_addr;
                ev_fl    = newf;
            end
        end
    end

    assign sts.done = ev_done;

    // Store write port: clearing sweep or walk updates
    assign mem_we    = cmd.clear | (cmd.eval & ev_we);
    assign mem_waddr = cmd.clear ? cmd.clr_addr : slot;
    assign mem_wdata = cmd.clear ? '0 : ev_wdata;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            store[mem_waddr] <= mem_wdata;
        end
        if (cmd.rd) begin
            pte_reg <= store[slot];
        end
    end

    // Latch the item and walk position
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            op_reg     <= s_op;
            va_reg     <= s_virt_addr;
            pa_ppn_reg <= s_phys_addr[55:12];
            tgt_reg    <= (s_op == OP_MAP) ? ((s_level >= 2'd2) ? 2'd2 : s_level) : 2'd0;
            u_reg      <= s_user;
            w_reg      <= s_writable;
            x_reg      <= s_executable;
            lvl_reg    <= 2'd3;
            page_reg   <= '0;
        end else if (cmd.eval && ev_desc) begin
            lvl_reg  <= lvl_reg - 2'd1;
            page_reg <= ev_page;
        end
        if (cmd.eval && ev_done) begin
            st_reg   <= ev_st;
            addr_reg <= ev_addr;
            fl_reg   <= ev_fl;
            ch_reg   <= ev_ch;
        end
    end

    // Advance the page pools
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ntp_reg <= NTP_W'(1);
            ndp_reg <= '0;
        end else if (cmd.eval) begin
            if (ev_alloc) begin
                ntp_reg <= ntp_reg + NTP_W'(1);
            end
            if (ev_dinc) begin
                ndp_reg <= ndp_reg + LIM_W'(1);
            end
        end
    end

    assign m_status        = st_reg;
    assign m_result_addr   = addr_reg;
    assign m_leaf_flags    = fl_reg;
    assign m_flags_changed = ch_reg;

endmodule

/* hdl/sv48ptw_ctrl.sv */
`timescale 1ns / 1ps
module sv48ptw_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output sv48ptw_pkg::cmd_t cmd,
    input  sv48ptw_pkg::sts_t sts
);
    import sv48ptw_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EVAL,
        S_RESP
    } state_t;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;

    // Next state
    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        case (state_reg)
            S_CLEAR: begin
                clr_next = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(STORE_DEPTH - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: if (s_valid) state_next = S_READ;
            S_READ: state_next = S_EVAL;
            S_EVAL: state_next = sts.done ? S_RESP : S_READ;
            S_RESP: if (m_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Hold state and sweep counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    // Commands and handshake
    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = (state_reg == S_RESP);
    assign cmd.start    = (state_reg == S_IDLE) && s_valid;
    assign cmd.clear    = (state_reg == S_CLEAR);
    assign cmd.clr_addr = clr_reg;
    assign cmd.rd       = (state_reg == S_READ);
    assign cmd.eval     = (state_reg == S_EVAL);

endmodule

/* hdl/sv48_page_table_walk_and_build.sv */
`timescale 1ns / 1ps
// Sv48 page table walker and builder over an on-chip table store of eight 4 KB table
// pages (root is page 0). After reset the store's 4096 entries are swept to zero, one
// entry a cycle, while s_ready stays low; APB writes are taken throughout. Each level
// of the walk is one registered read of the single-port store followed by one
// decide/write step; a walk reads 1 to 4 table levels. The result is held on the
// output until m_ready is high, and the walker returns to idle before it takes the
// next input, so one item is in flight at a time. Registers: 0x00 table_base_ppn,
// 0x08 data_base_ppn, 0x10 data_page_limit.
module sv48_page_table_walk_and_build (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [47:0] s_virt_addr,
    input  logic [55:0] s_phys_addr,
    input  logic [1:0]  s_level,
    input  logic        s_user,
    input  logic        s_writable,
    input  logic        s_executable,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [55:0] m_result_addr,
    output logic [4:0]  m_leaf_flags,
    output logic        m_flags_changed
);
    import sv48ptw_pkg::*;

    cmd_t              cmd;
    sts_t              sts;
    logic [PPN_W-1:0]  tbase_reg;
    logic [PPN_W-1:0]  dbase_reg;
    logic [LIM_W-1:0]  limit_reg;
    logic              wr_en;

    // Configuration registers
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tbase_reg <= '0;
            dbase_reg <= '0;
            limit_reg <= '0;
        end else if (wr_en) begin
            case (paddr[4:3])
                REG_TABLE_BASE: tbase_reg <= pwdata[PPN_W-1:0];
                REG_DATA_BASE:  dbase_reg <= pwdata[PPN_W-1:0];
                REG_DATA_LIMIT: limit_reg <= pwdata[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:3])
            REG_TABLE_BASE: prdata = {20'b0, tbase_reg};
            REG_DATA_BASE:  prdata = {20'b0, dbase_reg};
            REG_DATA_LIMIT: prdata = {32'b0, limit_reg};
            default:        prdata = '0;
        endcase
    end

    sv48ptw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    sv48ptw_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .s_op            (s_op),
        .s_virt_addr     (s_virt_addr),
        .s_phys_addr     (s_phys_addr),
        .s_level         (s_level),
        .s_user          (s_user),
        .s_writable      (s_writable),
        .s_executable    (s_executable),
        .table_base_ppn  (tbase_reg),
        .data_base_ppn   (dbase_reg),
        .data_page_limit (limit_reg),
        .m_status        (m_status),
        .m_result_addr   (m_result_addr),
        .m_leaf_flags    (m_leaf_flags),
        .m_flags_changed (m_flags_changed)
    );

endmodule

/* hdl/sv48ptw_chk.sv */
`timescale 1ns / 1ps
`include "sv48_page_table_walk_and_build_defines.svh"
module sv48ptw_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_status,
    input logic [55:0] m_result_addr,
    input logic [4:0]  m_leaf_flags,
    input logic        m_flags_changed
);
    import sv48ptw_pkg::*;

    // A stalled result holds
    `SV48PTW_ASSERT_NEXT(a_res_hold, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_result_addr))
    // Not-mapped and no-pages failures report no address and no flags
    `SV48PTW_ASSERT_NOW(a_fail_zero, m_valid && (m_status == ST_NOTMAPPED || m_status == ST_NOPAGES), m_result_addr == '0 && m_leaf_flags == '0)
    // A merge rewrite only comes with success
    `SV48PTW_ASSERT_NOW(a_merge_ok, m_valid && m_flags_changed, m_status == ST_OK)
    // A successful result names a valid leaf
    `SV48PTW_ASSERT_NOW(a_ok_valid, m_valid && m_status == ST_OK, m_leaf_flags[0])

endmodule

bind sv48_page_table_walk_and_build sv48ptw_chk u_chk (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_status        (m_status),
    .m_result_addr   (m_result_addr),
    .m_leaf_flags    (m_leaf_flags),
    .m_flags_changed (m_flags_changed)
);
